// ===== rtl/core/cab_hdr_pkg.sv =====
// ----------------------------------------------------------------------------
// Cabinet header detector package
// Transfer types, register indexes and fixed constants shared by the detector.
// ----------------------------------------------------------------------------
package cab_hdr_pkg;

    localparam int unsigned POS_W   = 40;
    localparam int unsigned SPAN_W  = 41;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Signature "MSCF" as it appears in the window, first byte highest.
    localparam logic [31:0] SIG_WORD = 32'h4D53_4346;

    localparam logic [COUNT_W-1:0] MAX_FILE_COUNT_RST = 16'd4000;
    localparam logic [7:0]         VERSION_MINOR_RST  = 8'd3;
    localparam logic [7:0]         VERSION_MAJOR_RST  = 8'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FILE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION_MINOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION_MAJOR  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_SEARCHING = 2'd0;
    localparam logic [1:0] ST_CANDIDATE = 2'd1;
    localparam logic [1:0] ST_DETECTED  = 2'd2;
    localparam logic [1:0] ST_HELD      = 2'd3;

    // Header offsets at which the candidate is checked.
    localparam logic [POS_W-1:0] OFS_RESERVED1 = 40'd15;
    localparam logic [POS_W-1:0] OFS_FILES_OFS = 40'd19;
    localparam logic [POS_W-1:0] OFS_RESERVED3 = 40'd23;
    localparam logic [POS_W-1:0] OFS_VER_MINOR = 40'd24;
    localparam logic [POS_W-1:0] OFS_VER_MAJOR = 40'd25;
    localparam logic [POS_W-1:0] OFS_FOLDERS   = 40'd27;
    localparam logic [POS_W-1:0] OFS_FILES     = 40'd29;
    localparam logic [POS_W-1:0] SIG_LAG       = 40'd11;

    typedef struct packed {
        logic              action;
        logic [7:0]        data_byte;
        logic [POS_W-1:0]  byte_pos;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_end;
    } out_item_t;

endpackage

// ===== rtl/core/cabinet_header_detector_top.sv =====
// ----------------------------------------------------------------------------
// Cabinet header detector
// Scans a byte stream for a cabinet header and reports the span of its data.
// ----------------------------------------------------------------------------
// The detector takes one stream byte per cycle and returns exactly one result
// per byte, registered in the cycle after the input transfer. The input is ready
// whenever the result register is empty or being emptied in the same cycle, so
// a continuous stream runs at one byte per clock and only backpressure on the
// result channel slows it. All header parsing happens in a single
// combinational pass from the held state to the result register; the data span
// additions are split so that no path chains two wide adds. Configuration
// writes are always accepted and should be made while the stream is idle.
module cabinet_header_detector_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  cab_hdr_pkg::in_item_t                s_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output cab_hdr_pkg::out_item_t               m_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cab_hdr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cab_hdr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_CAND   = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam int unsigned POS_W  = cab_hdr_pkg::POS_W;
    localparam int unsigned SPAN_W = cab_hdr_pkg::SPAN_W;
    localparam int unsigned MUL_W  = 21;

    // Configuration registers
    logic [15:0] max_file_count_reg;
    logic [7:0]  ver_minor_reg;
    logic [7:0]  ver_major_reg;

    // Parser state
    logic [31:0]       win0_reg, win1_reg, win2_reg;
    logic [31:0]       win0_next, win1_next, win2_next;
    logic [1:0]        phase_reg, phase_next;
    logic [POS_W-1:0]  header_pos_reg, header_pos_next;
    logic [31:0]       cab_size_reg, cab_size_next;
    logic [31:0]       files_ofs_reg, files_ofs_next;
    logic [MUL_W-1:0]  fc26_reg, fc26_next;
    logic [MUL_W-1:0]  fc20_reg, fc20_next;
    logic [SPAN_W-1:0] start_base_reg, start_base_next;
    logic [SPAN_W-1:0] end_base_reg, end_base_next;
    logic [SPAN_W-1:0] found_start_reg, found_start_next;
    logic [SPAN_W-1:0] found_end_reg, found_end_next;

    logic                   m_valid_reg;
    cab_hdr_pkg::out_item_t m_item_reg;
    cab_hdr_pkg::out_item_t result;

    logic              s_accept;
    logic [POS_W-1:0]  rel_pos;
    logic [32:0]       mark;
    logic [31:0]       le_word;
    logic [15:0]       le_half;
    logic [POS_W-1:0]  hdr_cand;
    logic [1:0]        status;

    assign s_accept  = s_valid && s_ready;
    assign s_ready   = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_file_count_reg <= cab_hdr_pkg::MAX_FILE_COUNT_RST;
            ver_minor_reg      <= cab_hdr_pkg::VERSION_MINOR_RST;
            ver_major_reg      <= cab_hdr_pkg::VERSION_MAJOR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cab_hdr_pkg::REG_MAX_FILE_COUNT: max_file_count_reg <= cfg_data;
                cab_hdr_pkg::REG_VERSION_MINOR:  ver_minor_reg      <= cfg_data[7:0];
                cab_hdr_pkg::REG_VERSION_MAJOR:  ver_major_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        win0_next        = {win0_reg[23:0], s_item.data_byte};
        win1_next        = {win1_reg[23:0], win0_reg[31:24]};
        win2_next        = {win2_reg[23:0], win1_reg[31:24]};
        phase_next       = phase_reg;
        header_pos_next  = header_pos_reg;
        cab_size_next    = cab_size_reg;
        files_ofs_next   = files_ofs_reg;
        fc26_next        = fc26_reg;
        fc20_next        = fc20_reg;
        start_base_next  = start_base_reg;
        end_base_next    = end_base_reg;
        found_start_next = found_start_reg;
        found_end_next   = found_end_reg;
        status           = cab_hdr_pkg::ST_SEARCHING;

        // Multi-byte header fields are little-endian; the newest byte is the
        // most significant one.
        le_word  = {win0_next[7:0], win0_next[15:8], win0_next[23:16], win0_next[31:24]};
        le_half  = {win0_next[7:0], win0_next[15:8]};
        hdr_cand = s_item.byte_pos - cab_hdr_pkg::SIG_LAG;
        rel_pos  = s_item.byte_pos - header_pos_reg;
        mark     = {1'b0, files_ofs_reg} + 33'd7;

        if (s_item.action) begin
            win0_next        = '0;
            win1_next        = '0;
            win2_next        = '0;
            phase_next       = PH_SEARCH;
            header_pos_next  = '0;
            cab_size_next    = '0;
            files_ofs_next   = '0;
            fc26_next        = '0;
            fc20_next        = '0;
            found_start_next = '0;
            found_end_next   = '0;
        end else begin
            case (phase_reg)
                PH_SEARCH: begin
                    if (win2_next == cab_hdr_pkg::SIG_WORD && win1_next == '0
                            && win0_next != '0) begin
                        phase_next      = PH_CAND;
                        header_pos_next = hdr_cand;
                        cab_size_next   = le_word;
                        files_ofs_next  = '0;
                        fc26_next       = '0;
                        fc20_next       = '0;
                        status          = cab_hdr_pkg::ST_CANDIDATE;
                    end
                end
                PH_CAND: begin
                    status = cab_hdr_pkg::ST_CANDIDATE;
                    if (rel_pos == cab_hdr_pkg::OFS_RESERVED1 && win0_next != '0) begin
                        phase_next = PH_SEARCH;
                    end else if (rel_pos == cab_hdr_pkg::OFS_FILES_OFS) begin
                        files_ofs_next  = le_word;
                        start_base_next = {1'b0, header_pos_reg} + {9'd0, le_word};
                        end_base_next   = {1'b0, header_pos_reg} + {9'd0, cab_size_reg};
                        if (le_word == '0 || le_word > cab_size_reg) begin
                            phase_next = PH_SEARCH;
                        end
                    end else if (rel_pos == cab_hdr_pkg::OFS_RESERVED3 && win0_next != '0) begin
                        phase_next = PH_SEARCH;
                    end else if (rel_pos == cab_hdr_pkg::OFS_VER_MINOR
                            && s_item.data_byte != ver_minor_reg) begin
                        phase_next = PH_SEARCH;
                    end else if (rel_pos == cab_hdr_pkg::OFS_VER_MAJOR
                            && s_item.data_byte != ver_major_reg) begin
                        phase_next = PH_SEARCH;
                    end else if (rel_pos == cab_hdr_pkg::OFS_FOLDERS) begin
                        if (le_half == '0) begin
                            phase_next = PH_SEARCH;
                        end
                    end else if (rel_pos == cab_hdr_pkg::OFS_FILES) begin
                        // Scale the file count now so the span is one add later.
                        fc26_next = MUL_W'({5'd0, le_half} * 21'd26);
                        fc20_next = MUL_W'({5'd0, le_half} * 21'd20);
                        if (le_half == '0 || le_half > max_file_count_reg) begin
                            phase_next = PH_SEARCH;
                        end
                    end else if (files_ofs_reg != '0 && rel_pos == {7'd0, mark}) begin
                        // The first byte of the first file entry must have its top bit clear.
                        if (win1_next[31]) begin
                            phase_next = PH_SEARCH;
                        end
                    end else if (files_ofs_reg != '0 && rel_pos > {7'd0, mark}) begin
                        found_start_next = start_base_reg + {20'd0, fc26_reg};
                        found_end_next   = end_base_reg + {20'd0, fc20_reg};
                        phase_next       = PH_DONE;
                        status           = cab_hdr_pkg::ST_DETECTED;
                    end
                    if (phase_next == PH_SEARCH) begin
                        status = cab_hdr_pkg::ST_SEARCHING;
                    end
                end
                default: begin
                    status = cab_hdr_pkg::ST_HELD;
                end
            endcase
        end

        result.status     = status;
        result.span_start = found_start_next;
        result.span_end   = found_end_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            phase_reg       <= PH_SEARCH;
            win0_reg        <= '0;
            win1_reg        <= '0;
            win2_reg        <= '0;
            header_pos_reg  <= '0;
            cab_size_reg    <= '0;
            files_ofs_reg   <= '0;
            fc26_reg        <= '0;
            fc20_reg        <= '0;
            start_base_reg  <= '0;
            end_base_reg    <= '0;
            found_start_reg <= '0;
            found_end_reg   <= '0;
        end else begin
            if (s_accept) begin
                m_valid_reg     <= 1'b1;
                phase_reg       <= phase_next;
                win0_reg        <= win0_next;
                win1_reg        <= win1_next;
                win2_reg        <= win2_next;
                header_pos_reg  <= header_pos_next;
                cab_size_reg    <= cab_size_next;
                files_ofs_reg   <= files_ofs_next;
                fc26_reg        <= fc26_next;
                fc20_reg        <= fc20_next;
                start_base_reg  <= start_base_next;
                end_base_reg    <= end_base_next;
                found_start_reg <= found_start_next;
                found_end_reg   <= found_end_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_item_reg <= result;
        end
    end

    // A result that reports no detection carries zero spans.
    a_span_zero_unless_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_item_reg.status == cab_hdr_pkg::ST_SEARCHING
                        || m_item_reg.status == cab_hdr_pkg::ST_CANDIDATE)
        |-> m_item_reg.span_start == '0 && m_item_reg.span_end == '0)
        else $error("span reported without detection");

    // Once detected, the spans hold until a reset action is transferred.
    a_span_held: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE && !(s_accept && s_item.action)
        |=> $stable(found_start_reg) && $stable(found_end_reg))
        else $error("held span changed");

    // While searching no span is remembered.
    a_search_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SEARCH |-> found_start_reg == '0 && found_end_reg == '0)
        else $error("stale span in search state");

endmodule
